[src/rmd160_pkg.sv]
// Package for the RIPEMD-160 hash engine: sequencer states and round constants.
// Used by ripemd160_hash_engine; no dependencies.
package rmd160_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } t_state;

    localparam logic [31:0] INIT_0 = 32'h67452301;
    localparam logic [31:0] INIT_1 = 32'hEFCDAB89;
    localparam logic [31:0] INIT_2 = 32'h98BADCFE;
    localparam logic [31:0] INIT_3 = 32'h10325476;
    localparam logic [31:0] INIT_4 = 32'hC3D2E1F0;

    localparam logic [6:0] ROUNDS = 7'd80;

    function automatic logic [3:0] sel_l(input logic [6:0] j);
        logic [3:0] t [80];
        t = '{4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,
              4'd14,4'd15,
              4'd7,4'd4,4'd13,4'd1,4'd10,4'd6,4'd15,4'd3,4'd12,4'd0,4'd9,4'd5,4'd2,4'd14,
              4'd11,4'd8,
              4'd3,4'd10,4'd14,4'd4,4'd9,4'd15,4'd8,4'd1,4'd2,4'd7,4'd0,4'd6,4'd13,4'd11,
              4'd5,4'd12,
              4'd1,4'd9,4'd11,4'd10,4'd0,4'd8,4'd12,4'd4,4'd13,4'd3,4'd7,4'd15,4'd14,4'd5,
              4'd6,4'd2,
              4'd4,4'd0,4'd5,4'd9,4'd7,4'd12,4'd2,4'd10,4'd14,4'd1,4'd3,4'd8,4'd11,4'd6,
              4'd15,4'd13};
        return t[j];
    endfunction

    function automatic logic [3:0] sel_r(input logic [6:0] j);
        logic [3:0] t [80];
        t = '{4'd5,4'd14,4'd7,4'd0,4'd9,4'd2,4'd11,4'd4,4'd13,4'd6,4'd15,4'd8,4'd1,4'd10,
              4'd3,4'd12,
              4'd6,4'd11,4'd3,4'd7,4'd0,4'd13,4'd5,4'd10,4'd14,4'd15,4'd8,4'd12,4'd4,4'd9,
              4'd1,4'd2,
              4'd15,4'd5,4'd1,4'd3,4'd7,4'd14,4'd6,4'd9,4'd11,4'd8,4'd12,4'd2,4'd10,4'd0,
              4'd4,4'd13,
              4'd8,4'd6,4'd4,4'd1,4'd3,4'd11,4'd15,4'd0,4'd5,4'd12,4'd2,4'd13,4'd9,4'd7,
              4'd10,4'd14,
              4'd12,4'd15,4'd10,4'd4,4'd1,4'd5,4'd8,4'd7,4'd6,4'd2,4'd13,4'd14,4'd0,4'd3,
              4'd9,4'd11};
        return t[j];
    endfunction

    function automatic logic [4:0] rot_l(input logic [6:0] j);
        logic [4:0] t [80];
        t = '{5'd11,5'd14,5'd15,5'd12,5'd5,5'd8,5'd7,5'd9,5'd11,5'd13,5'd14,5'd15,5'd6,
              5'd7,5'd9,5'd8,
              5'd7,5'd6,5'd8,5'd13,5'd11,5'd9,5'd7,5'd15,5'd7,5'd12,5'd15,5'd9,5'd11,5'd7,
              5'd13,5'd12,
              5'd11,5'd13,5'd6,5'd7,5'd14,5'd9,5'd13,5'd15,5'd14,5'd8,5'd13,5'd6,5'd5,
              5'd12,5'd7,5'd5,
              5'd11,5'd12,5'd14,5'd15,5'd14,5'd15,5'd9,5'd8,5'd9,5'd14,5'd5,5'd6,5'd8,5'd6,
              5'd5,5'd12,
              5'd9,5'd15,5'd5,5'd11,5'd6,5'd8,5'd13,5'd12,5'd5,5'd12,5'd13,5'd14,5'd11,
              5'd8,5'd5,5'd6};
        return t[j];
    endfunction

    function automatic logic [4:0] rot_r(input logic [6:0] j);
        logic [4:0] t [80];
        t = '{5'd8,5'd9,5'd9,5'd11,5'd13,5'd15,5'd15,5'd5,5'd7,5'd7,5'd8,5'd11,5'd14,
              5'd14,5'd12,5'd6,
              5'd9,5'd13,5'd15,5'd7,5'd12,5'd8,5'd9,5'd11,5'd7,5'd7,5'd12,5'd7,5'd6,5'd15,
              5'd13,5'd11,
              5'd9,5'd7,5'd15,5'd11,5'd8,5'd6,5'd6,5'd14,5'd12,5'd13,5'd5,5'd14,5'd13,
              5'd13,5'd7,5'd5,
              5'd15,5'd5,5'd8,5'd11,5'd14,5'd14,5'd6,5'd14,5'd6,5'd9,5'd12,5'd9,5'd12,5'd5,
              5'd15,5'd8,
              5'd8,5'd5,5'd12,5'd9,5'd12,5'd5,5'd14,5'd6,5'd8,5'd13,5'd6,5'd5,5'd15,5'd13,
              5'd11,5'd11};
        return t[j];
    endfunction

    function automatic logic [31:0] add_l(input logic [2:0] r);
        case (r)
            3'd0:    return 32'h00000000;
            3'd1:    return 32'h5A827999;
            3'd2:    return 32'h6ED9EBA1;
            3'd3:    return 32'h8F1BBCDC;
            default: return 32'hA953FD4E;
        endcase
    endfunction

    function automatic logic [31:0] add_r(input logic [2:0] r);
        case (r)
            3'd0:    return 32'h50A28BE6;
            3'd1:    return 32'h5C4DD124;
            3'd2:    return 32'h6D703EF3;
            3'd3:    return 32'h7A6D76E9;
            default: return 32'h00000000;
        endcase
    endfunction

    function automatic logic [31:0] bool_fn(input logic [2:0] k, input logic [31:0] x,
                                            input logic [31:0] y, input logic [31:0] z);
        case (k)
            3'd0:    return x ^ y ^ z;
            3'd1:    return (x & y) | (~x & z);
            3'd2:    return (x | ~y) ^ z;
            3'd3:    return (x & z) | (y & ~z);
            default: return x ^ (y | ~z);
        endcase
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

endpackage

[src/ripemd160_hash_engine.sv]
// RIPEMD-160 hash engine top level: byte absorber, padding sequencer, round unit.
// Depends on rmd160_pkg.
//
// One message byte per transaction, accepted while the block
// buffer fills. The 64th byte of a block starts a compression: one step of
// both lines per cycle through a single round unit, then the chaining
// update, during all of which the input is not ready. An end item pads one byte
// per cycle between compressions (length bytes included), runs one or two
// compressions, then hands out the five digest words, one per accepted output
// transaction.
// The block buffer has no reset; every word is written before it is read.
module ripemd160_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import rmd160_pkg::*;

    t_state      r_state, n_state;
    t_state      r_ret, n_ret;
    logic [31:0] r_buf [16];
    logic [31:0] r_h [5];
    logic [31:0] r_al, r_bl, r_cl, r_dl, r_el, r_ar, r_br, r_cr, r_dr, r_er;
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [63:0] r_len;
    logic [6:0]  r_step;
    logic [2:0]  r_widx;

    logic        s_in_fire, s_out_fire;
    logic        s_wr;
    logic [7:0]  s_wbyte;
    logic        s_full;
    logic [2:0]  s_rnd;
    logic [31:0] s_tl, s_tr;
    logic [31:0] s_fl, s_fr;

    assign s_in_fire  = i_valid && o_ready;
    assign s_out_fire = o_valid && i_ready;
    assign s_rnd      = r_step[6:4] > 3'd4 ? 3'd4 : r_step[6:4];
    assign s_full     = (r_fill == 6'd63);

    always_comb begin
        s_wr    = 1'b0;
        s_wbyte = i_data_byte;
        case (r_state)
            ST_IDLE: begin
                s_wr = s_in_fire && i_byte_valid;
            end
            ST_PAD: begin
                s_wr    = 1'b1;
                s_wbyte = 8'h00;
            end
            ST_LEN: begin
                s_wr    = 1'b1;
                s_wbyte = r_len[8*(r_fill[2:0])+:8];
            end
            default: s_wr = 1'b0;
        endcase
    end

    // first pad byte 0x80 is issued on entry to ST_PAD via r_pad80
    logic r_pad80;

    always_comb begin
        s_fl = bool_fn(s_rnd, r_bl, r_cl, r_dl);
        s_fr = bool_fn(3'd4 - s_rnd, r_br, r_cr, r_dr);
        s_tl = rotl(r_al + s_fl + r_buf[sel_l(r_step)] + add_l(s_rnd), rot_l(r_step)) + r_el;
        s_tr = rotl(r_ar + s_fr + r_buf[sel_r(r_step)] + add_r(s_rnd), rot_r(r_step)) + r_er;
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        case (r_state)
            ST_IDLE: begin
                if (s_in_fire) begin
                    if (i_byte_valid && s_full) begin
                        n_state = ST_ROUND;
                        n_ret   = i_end_of_message ? ST_PAD : ST_IDLE;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (s_full) begin
                    n_state = ST_ROUND;
                    n_ret   = ST_PAD;
                end else if (r_fill == 6'd55) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                if (s_full) begin
                    n_state = ST_ROUND;
                    n_ret   = ST_EMIT;
                end
            end
            ST_ROUND: begin
                if (r_step == ROUNDS - 7'd1) n_state = ST_FINAL;
            end
            ST_FINAL: n_state = r_ret;
            ST_EMIT: begin
                if (s_out_fire && r_widx == 3'd4) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready       = (r_state == ST_IDLE);
        o_valid       = (r_state == ST_EMIT);
        o_digest_word = r_h[r_widx];
        o_word_index  = r_widx;
        o_last_word   = (r_widx == 3'd4);
    end

    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            r_buf[r_fill[5:2]][8*r_fill[1:0]+:8] <= (r_state == ST_PAD && r_pad80)
                                                    ? 8'h80 : s_wbyte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_ROUND) begin
            r_al <= r_el; r_el <= r_dl; r_dl <= rotl(r_cl, 5'd10); r_cl <= r_bl; r_bl <= s_tl;
            r_ar <= r_er; r_er <= r_dr; r_dr <= rotl(r_cr, 5'd10); r_cr <= r_br; r_br <= s_tr;
        end else begin
            r_al <= r_h[0]; r_bl <= r_h[1]; r_cl <= r_h[2]; r_dl <= r_h[3]; r_el <= r_h[4];
            r_ar <= r_h[0]; r_br <= r_h[1]; r_cr <= r_h[2]; r_dr <= r_h[3]; r_er <= r_h[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_fill  <= '0;
            r_bits  <= '0;
            r_len   <= '0;
            r_step  <= '0;
            r_widx  <= '0;
            r_pad80 <= 1'b0;
            r_h[0]  <= INIT_0; r_h[1] <= INIT_1; r_h[2] <= INIT_2;
            r_h[3]  <= INIT_3; r_h[4] <= INIT_4;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            if (s_wr) r_fill <= r_fill + 6'd1;
            if (r_state == ST_IDLE && s_in_fire) begin
                if (i_byte_valid) r_bits <= r_bits + 64'd8;
                if (i_end_of_message) begin
                    r_len   <= i_byte_valid ? r_bits + 64'd8 : r_bits;
                    r_pad80 <= 1'b1;
                end
            end
            if (r_state == ST_PAD) r_pad80 <= 1'b0;
            if (r_state == ST_ROUND) r_step <= r_step + 7'd1;
            else r_step <= '0;
            if (r_state == ST_FINAL) begin
                r_h[0] <= r_h[1] + r_cl + r_dr;
                r_h[1] <= r_h[2] + r_dl + r_er;
                r_h[2] <= r_h[3] + r_el + r_ar;
                r_h[3] <= r_h[4] + r_al + r_br;
                r_h[4] <= r_h[0] + r_bl + r_cr;
            end
            if (s_out_fire) begin
                if (r_widx == 3'd4) begin
                    r_widx <= '0;
                    r_fill <= '0;
                    r_bits <= '0;
                    r_h[0] <= INIT_0; r_h[1] <= INIT_1; r_h[2] <= INIT_2;
                    r_h[3] <= INIT_3; r_h[4] <= INIT_4;
                end else begin
                    r_widx <= r_widx + 3'd1;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_emit_only_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_fill == 6'd0 && r_widx <= 3'd4))
        else $error("digest emitted with partial block");
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_step < ROUNDS))
        else $error("round counter overran");
    a_final_after_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINAL) |-> $past(r_state == ST_ROUND && r_step == ROUNDS - 7'd1))
        else $error("chaining update without full round sequence");
`endif

endmodule
